[rtl/bti_pkg.sv]
// Shared types, codes and defaults of the breakpoint table interpolation block.
`timescale 1ns / 1ps

package bti_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int IDX_W     = 6;
	localparam int GAP_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DESC  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 2'd3;

	localparam logic [IDX_W-1:0] RST_FIRST   = 6'd0;
	localparam logic [IDX_W-1:0] RST_LAST    = 6'd63;
	localparam logic             RST_DESC    = 1'b0;
	localparam logic [GAP_W-1:0] RST_MIN_GAP = 16'd1;

	// Item operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		RG_BELOW  = 2'd0,
		RG_ABOVE  = 2'd1,
		RG_DUP    = 2'd2,
		RG_INTERP = 2'd3
	} region_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIFF,
		ST_MAG,
		ST_MUL,
		ST_DCHK,
		ST_DIV,
		ST_ADD,
		ST_SAT,
		ST_FIN
	} state_t;

endpackage

[rtl/breakpoint_table_interpolation.sv]
// Top level: breakpoint table, query sequencer and configuration registers.
// Usage:
//  Items enter on in_valid/in_ready with op, entry_index, x_value, y_value.
//  A write item (op 0) stores an (x,y) breakpoint and answers with write_ack
//  set; a query item (op 1) scans the configured index range and answers
//  with the clamped, duplicate or interpolated y on y_result.
//  Results leave on out_valid/out_ready from an output register, so the next
//  item is taken while a result still waits; a stalled receiver holds the
//  block in its final step only once the next result is ready.
//  A write goes straight to the final step. A query scans the configured
//  range, one table read a cycle, visiting 1 to last_entry-first_entry+1
//  entries, then runs a shift-and-add multiply of VALUE_WIDTH+1 steps and
//  a restoring divide of VALUE_WIDTH+2 steps on the shared adder, then the
//  final sum and saturation. A clamped answer skips the arithmetic, a
//  duplicate x the multiply and divide, and an overflowing quotient the
//  remaining steps. One item is in work at a time.
//  Configuration is to be written on cfg_write/cfg_index/cfg_data only
//  while idle; the block itself does not enforce this.
//  Reset (arst_n low) restores the register defaults and empties the output;
//  the table holds no defined contents until written.
`timescale 1ns / 1ps

module breakpoint_table_interpolation #(
	parameter int TABLE_DEPTH = bti_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = bti_pkg::DEF_VALUE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bti_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [bti_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [VALUE_WIDTH-1:0]     x_value,
	input  logic signed [VALUE_WIDTH-1:0]     y_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [VALUE_WIDTH-1:0]     y_result,
	output logic [1:0]                        region,
	output logic [bti_pkg::IDX_W-1:0]         segment,
	output logic                              write_ack
);

	localparam int VW   = VALUE_WIDTH;
	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int W1   = VW + 1;
	localparam int PW   = 2 * W1;
	localparam int QW   = VW + 2;
	localparam int UW   = VW + 3;
	localparam int GW   = (W1 > bti_pkg::GAP_W) ? W1 : bti_pkg::GAP_W;
	localparam int CNTW = $clog2(UW);

	localparam logic [VW-1:0] VMAX  = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] VMIN  = {1'b1, {(VW-1){1'b0}}};
	localparam logic [UW-1:0] VMAXU = {{(UW-VW){1'b0}}, VMAX};
	localparam logic [UW-1:0] VMINU = {{(UW-VW){1'b1}}, VMIN};
	localparam logic [QW-1:0] Q_LIM = {1'b1, {(QW-1){1'b0}}};

	// Configuration registers
	logic [bti_pkg::IDX_W-1:0] first_entry_q;
	logic [bti_pkg::IDX_W-1:0] last_entry_q;
	logic                      descending_q;
	logic [bti_pkg::GAP_W-1:0] min_gap_q;

	bti_pkg::state_t state_q, state_d;

	logic [AW-1:0]   lo_c, hi_c, lo_q, hi_q, i_q, rd_addr;
	logic [VW-1:0]   x_q;
	logic [2*VW-1:0] rd_data, prev_q;
	logic [W1-1:0]   dy_q, ux_q, dx_q;
	logic [W1-1:0]   mcand_q, dvsr_q, rem_q;
	logic [PW-1:0]   prod_q;
	logic [QW-1:0]   quo_q;
	logic [UW-1:0]   sum_q;
	logic            neg_q;
	logic [CNTW-1:0] cnt_q;

	logic [VW-1:0]             res_y_q;
	logic [1:0]                res_region_q;
	logic [bti_pkg::IDX_W-1:0] res_seg_q;
	logic                      res_ack_q;
	logic                      out_valid_q;
	logic [VW-1:0]             out_y_q;
	logic [1:0]                out_region_q;
	logic [bti_pkg::IDX_W-1:0] out_seg_q;
	logic                      out_ack_q;

	logic            accept, mem_we, out_load;
	logic [UW-1:0]   alu_a, alu_b, alu_y;
	logic            alu_sub;

	logic [VW-1:0]   rdx, rdy, prx, pry;
	logic            lt, eq, cond, beyond, adv;
	logic [W1-1:0]   dy_mag, ux_mag, dx_mag;
	logic            dup;
	logic [W1:0]     div_t;
	logic            borrow;
	logic [W1:0]     mul_hi;
	logic [VW-1:0]   ph;
	logic            ph_over;

	// Index range clamped to the table depth
	assign lo_c = (32'(first_entry_q) >= TABLE_DEPTH) ? AW'(TABLE_DEPTH - 1)
	                                                  : AW'(first_entry_q);
	assign hi_c = (32'(last_entry_q) >= TABLE_DEPTH) ? AW'(TABLE_DEPTH - 1)
	                                                 : AW'(last_entry_q);

	assign accept = in_valid && in_ready;
	assign mem_we = accept && (op == bti_pkg::OP_WRITE) && (32'(entry_index) < TABLE_DEPTH);

	bti_table #(
		.DEPTH (TABLE_DEPTH),
		.DW    (2 * VW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(entry_index)),
		.wdata ({x_value, y_value}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bti_alu #(
		.W (UW)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	assign rdx = rd_data[2*VW-1:VW];
	assign rdy = rd_data[VW-1:0];
	assign prx = prev_q[2*VW-1:VW];
	assign pry = prev_q[VW-1:0];

	// Scan compare of the current breakpoint against the query x
	assign lt     = $signed(rdx) < $signed(x_q);
	assign eq     = rdx == x_q;
	assign cond   = descending_q ? !lt : (lt || eq);
	assign beyond = descending_q ? (!lt && !eq) : lt;
	assign adv    = (i_q < hi_q) && cond;

	assign dy_mag = dy_q[W1-1] ? (~dy_q + 1'b1) : dy_q;
	assign ux_mag = ux_q[W1-1] ? (~ux_q + 1'b1) : ux_q;
	assign dx_mag = dx_q[W1-1] ? (~dx_q + 1'b1) : dx_q;
	assign dup    = (dx_mag == '0) || (GW'(dx_mag) < GW'(min_gap_q));

	assign mul_hi  = prod_q[0] ? alu_y[W1:0] : {1'b0, prod_q[PW-1:W1]};
	assign div_t   = {rem_q, quo_q[QW-1]};
	assign borrow  = alu_y[UW-1];
	assign ph      = prod_q[PW-1:QW];
	assign ph_over = {1'b0, ph} >= dvsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_entry_q <= bti_pkg::RST_FIRST;
			last_entry_q  <= bti_pkg::RST_LAST;
			descending_q  <= bti_pkg::RST_DESC;
			min_gap_q     <= bti_pkg::RST_MIN_GAP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bti_pkg::CFG_FIRST: first_entry_q <= cfg_data[bti_pkg::IDX_W-1:0];
				bti_pkg::CFG_LAST:  last_entry_q  <= cfg_data[bti_pkg::IDX_W-1:0];
				bti_pkg::CFG_DESC:  descending_q  <= cfg_data[0];
				bti_pkg::CFG_GAP:   min_gap_q     <= cfg_data;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		rd_addr  = i_q;
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		unique case (state_q)
			bti_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = lo_c;
				if (in_valid) begin
					state_d = (op == bti_pkg::OP_WRITE) ? bti_pkg::ST_FIN : bti_pkg::ST_SCAN;
				end
			end
			bti_pkg::ST_SCAN: begin
				if (adv) begin
					rd_addr = i_q + 1'b1;
				end else if ((i_q == lo_q) || ((i_q == hi_q) && beyond)) begin
					state_d = bti_pkg::ST_FIN;
				end else begin
					state_d = bti_pkg::ST_DIFF;
				end
			end
			bti_pkg::ST_DIFF: state_d = bti_pkg::ST_MAG;
			bti_pkg::ST_MAG:  state_d = dup ? bti_pkg::ST_FIN : bti_pkg::ST_MUL;
			bti_pkg::ST_MUL: begin
				alu_a = UW'(prod_q[PW-1:W1]);
				alu_b = UW'(mcand_q);
				if (cnt_q == CNTW'(W1 - 1)) begin
					state_d = bti_pkg::ST_DCHK;
				end
			end
			bti_pkg::ST_DCHK: state_d = ph_over ? bti_pkg::ST_FIN : bti_pkg::ST_DIV;
			bti_pkg::ST_DIV: begin
				alu_a   = UW'(div_t);
				alu_b   = UW'(dvsr_q);
				alu_sub = 1'b1;
				if (cnt_q == CNTW'(QW - 1)) begin
					state_d = bti_pkg::ST_ADD;
				end
			end
			bti_pkg::ST_ADD: begin
				alu_a   = {{(UW-VW){pry[VW-1]}}, pry};
				alu_b   = UW'(quo_q);
				alu_sub = neg_q;
				state_d = (quo_q > Q_LIM) ? bti_pkg::ST_FIN : bti_pkg::ST_SAT;
			end
			bti_pkg::ST_SAT: state_d = bti_pkg::ST_FIN;
			bti_pkg::ST_FIN: begin
				// Hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = bti_pkg::ST_IDLE;
				end
			end
			default: state_d = bti_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bti_pkg::ST_IDLE: begin
				if (accept) begin
					x_q  <= x_value;
					i_q  <= lo_c;
					lo_q <= lo_c;
					hi_q <= hi_c;
					if (op == bti_pkg::OP_WRITE) begin
						res_y_q      <= '0;
						res_region_q <= bti_pkg::RG_BELOW;
						res_seg_q    <= '0;
						res_ack_q    <= 1'b1;
					end else begin
						res_ack_q <= 1'b0;
					end
				end
			end
			bti_pkg::ST_SCAN: begin
				res_seg_q <= bti_pkg::IDX_W'(i_q);
				if (adv) begin
					prev_q <= rd_data;
					i_q    <= i_q + 1'b1;
				end else if (i_q == lo_q) begin
					res_y_q      <= rdy;
					res_region_q <= bti_pkg::RG_BELOW;
				end else if ((i_q == hi_q) && beyond) begin
					res_y_q      <= rdy;
					res_region_q <= bti_pkg::RG_ABOVE;
				end
			end
			bti_pkg::ST_DIFF: begin
				dy_q <= {rdy[VW-1], rdy} - {pry[VW-1], pry};
				ux_q <= {x_q[VW-1], x_q} - {prx[VW-1], prx};
				dx_q <= {rdx[VW-1], rdx} - {prx[VW-1], prx};
			end
			bti_pkg::ST_MAG: begin
				mcand_q <= dy_mag;
				prod_q  <= {{W1{1'b0}}, ux_mag};
				dvsr_q  <= dx_mag;
				neg_q   <= dy_q[W1-1] ^ ux_q[W1-1] ^ dx_q[W1-1];
				cnt_q   <= '0;
				if (dup) begin
					res_y_q      <= rdy;
					res_region_q <= bti_pkg::RG_DUP;
				end else begin
					res_region_q <= bti_pkg::RG_INTERP;
				end
			end
			bti_pkg::ST_MUL: begin
				prod_q <= {mul_hi, prod_q[W1-1:1]};
				cnt_q  <= cnt_q + 1'b1;
			end
			bti_pkg::ST_DCHK: begin
				rem_q <= W1'(ph);
				quo_q <= prod_q[QW-1:0];
				cnt_q <= '0;
				res_y_q <= neg_q ? VMIN : VMAX;
			end
			bti_pkg::ST_DIV: begin
				rem_q <= borrow ? div_t[W1-1:0] : alu_y[W1-1:0];
				quo_q <= {quo_q[QW-2:0], !borrow};
				cnt_q <= cnt_q + 1'b1;
			end
			bti_pkg::ST_ADD: begin
				sum_q   <= alu_y;
				res_y_q <= neg_q ? VMIN : VMAX;
			end
			bti_pkg::ST_SAT: begin
				if ($signed(sum_q) > $signed(VMAXU)) begin
					res_y_q <= VMAX;
				end else if ($signed(sum_q) < $signed(VMINU)) begin
					res_y_q <= VMIN;
				end else begin
					res_y_q <= sum_q[VW-1:0];
				end
			end
			bti_pkg::ST_FIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_y_q      <= res_y_q;
			out_region_q <= res_region_q;
			out_seg_q    <= res_seg_q;
			out_ack_q    <= res_ack_q;
		end
	end

	assign out_valid = out_valid_q;
	assign y_result  = out_y_q;
	assign region    = out_region_q;
	assign segment   = out_seg_q;
	assign write_ack = out_ack_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != bti_pkg::ST_IDLE))
		else $error("accepted beat left the sequencer idle");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bti_pkg::ST_SCAN) |-> ((i_q >= lo_q) && ((i_q <= hi_q) || (i_q == lo_q))))
		else $error("scan index outside the latched range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bti_pkg::ST_DIV) |-> (rem_q < dvsr_q))
		else $error("divider remainder not below divisor");

	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_ack) |-> ((y_result == '0) && (region == bti_pkg::RG_BELOW)
		&& (segment == '0)))
		else $error("write acknowledge carries non-zero fields");
`endif

endmodule

[rtl/bti_table.sv]
// Breakpoint table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bti_table #(
	parameter int DEPTH = bti_pkg::DEF_TABLE_DEPTH,
	parameter int DW    = 2 * bti_pkg::DEF_VALUE_WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/bti_alu.sv]
// Shared adder/subtractor used by the multiply, divide and final sum steps.
`timescale 1ns / 1ps

module bti_alu #(
	parameter int W = bti_pkg::DEF_VALUE_WIDTH + 3
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] y
);

	assign y = sub ? (a - b) : (a + b);

endmodule
